### sv/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test
// Holds the word types of both channels, the command codes, the sequencer
// states and the signed arithmetic types of the edge unit.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Coordinate width of the vertex store and of the query point.
    localparam int COORD_BITS   = 12;
    // Default capacity of the vertex store.
    localparam int MAX_VERTICES = 64;
    // Width of the crossing count in the result word, and its ceiling.
    localparam int CROSS_BITS   = 7;
    localparam int CROSS_MAX    = 127;

    // Command codes.
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef logic [COORD_BITS-1:0] t_coord;

    // Input word: one command with its point.
    typedef struct packed {
        logic [1:0] command;
        t_coord     point_x;
        t_coord     point_y;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic                  inside_res;
        logic [CROSS_BITS-1:0] crossings;
        logic                  full_error;
    } t_out_word;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // Signed difference of two coordinates, product of two differences,
    // and the side value formed from two products.
    typedef logic signed [COORD_BITS:0]     t_sdiff;
    typedef logic signed [2*COORD_BITS+1:0] t_prod;
    typedef logic signed [2*COORD_BITS+2:0] t_side;

    // One edge handed to the edge unit.
    typedef struct packed {
        logic   valid;
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
    } t_edge;

    // Status returned by the edge unit.
    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } t_edge_status;

endpackage

### sv/pip_edge_unit.sv
// ----------------------------------------------------------------------------
// pip_edge_unit: shared crossing test for one polygon edge per cycle
// Takes an edge A->B and the query point, forms the three cross-product
// terms in a multiply stage, then compares the signs of the two sides in a
// second stage and reports whether the ray crosses the edge.
// ----------------------------------------------------------------------------
module pip_edge_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pip_pkg::t_edge        i_edge,
    input  pip_pkg::t_coord       i_px,
    input  pip_pkg::t_coord       i_py,
    output pip_pkg::t_edge_status o_status
);

    pip_pkg::t_sdiff dx, dy, pay, pax, ax_s;
    pip_pkg::t_coord lo_y, hi_y;
    logic            span;

    pip_pkg::t_prod  r_t, r_u, r_w;
    logic            r_span;
    logic            r_b_valid;

    pip_pkg::t_side  side_point, side_axis;
    logic            r_hit;
    logic            r_hit_valid;

    // Differences and the y span test of the edge.
    always_comb begin
        ax_s = pip_pkg::t_sdiff'({1'b0, i_edge.ax});
        dx   = pip_pkg::t_sdiff'({1'b0, i_edge.bx}) - ax_s;
        dy   = pip_pkg::t_sdiff'({1'b0, i_edge.by}) - pip_pkg::t_sdiff'({1'b0, i_edge.ay});
        pay  = pip_pkg::t_sdiff'({1'b0, i_py}) - pip_pkg::t_sdiff'({1'b0, i_edge.ay});
        pax  = pip_pkg::t_sdiff'({1'b0, i_px}) - ax_s;
        lo_y = (i_edge.ay < i_edge.by) ? i_edge.ay : i_edge.by;
        hi_y = (i_edge.ay < i_edge.by) ? i_edge.by : i_edge.ay;
        span = (dy != '0) && (i_py >= lo_y) && (i_py <= hi_y);
    end

    // Multiply stage: dx*(py-ay), dy*(px-ax) and dy*ax.
    always_ff @(posedge i_clk) begin
        r_t    <= pip_pkg::t_prod'(dx) * pip_pkg::t_prod'(pay);
        r_u    <= pip_pkg::t_prod'(dy) * pip_pkg::t_prod'(pax);
        r_w    <= pip_pkg::t_prod'(dy) * pip_pkg::t_prod'(ax_s);
        r_span <= span;
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= i_edge.valid;
        end
    end

    // Side values of the point and of the ray's end on the y axis.
    always_comb begin
        side_point = pip_pkg::t_side'(r_t) - pip_pkg::t_side'(r_u);
        side_axis  = pip_pkg::t_side'(r_t) + pip_pkg::t_side'(r_w);
    end

    // Compare stage: the ray crosses when the two ends lie on opposite sides.
    always_ff @(posedge i_clk) begin
        r_hit <= r_span && (side_point[$bits(pip_pkg::t_side)-1]
                            != side_axis[$bits(pip_pkg::t_side)-1]);
        if (!i_rst_n) begin
            r_hit_valid <= 1'b0;
        end else begin
            r_hit_valid <= r_b_valid;
        end
    end

    assign o_status.busy      = r_b_valid || r_hit_valid;
    assign o_status.hit_valid = r_hit_valid;
    assign o_status.hit       = r_hit;

endmodule

### sv/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test: polygon store with crossing-number point queries
// Keeps an ordered list of vertices. A word appends a vertex, clears the
// list or queries a point; each word yields exactly one result word.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                              Direction  Payload
//  -------  -----------------------------------  ---------  ----------
//  input    i_in_valid / o_in_ready / i_in_data  in         t_in_word
//  output   o_out_valid / i_out_ready / o_out_data  out     t_out_word
//
//  An append, clear or unused command goes from idle straight to the finish
//  state. A query over a non-empty list walks, drains and finishes: the
//  sequencer reads one vertex per cycle from the store and the shared edge
//  unit tests one edge per cycle through its multiply and compare stages.
//  Reset is synchronous and clears the vertex count; the store itself is
//  not cleared. A stalled result waits in the output register while the
//  next word is taken; that word's result waits until the register is free.
//
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pip_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pip_pkg::t_out_word o_out_data
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    pip_pkg::t_state r_state, n_state;

    pip_pkg::t_coord mem_x [MAX_VERTICES];
    pip_pkg::t_coord mem_y [MAX_VERTICES];

    logic [CW-1:0]   r_vcount;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   r_idx;
    logic [AW-1:0]   last_idx;
    logic [1:0]      r_cmd;
    logic            r_full;
    pip_pkg::t_coord r_px, r_py;

    pip_pkg::t_coord r_rd_x, r_rd_y;
    logic            r_rd_v, r_rd_last;
    logic            r_close;
    logic            r_have_prev;
    pip_pkg::t_coord r_prev_x, r_prev_y, r_first_x, r_first_y;

    pip_pkg::t_edge        edge_in;
    pip_pkg::t_edge_status edge_st;

    logic                  in_acc;
    logic                  store_full;
    logic                  do_append;
    logic                  walk_busy;
    logic                  out_free;
    pip_pkg::t_out_word    result;
    pip_pkg::t_out_word    r_out;
    logic                  r_out_valid;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == pip_pkg::ST_IDLE);
    assign store_full = (32'(r_vcount) >= 32'(MAX_VERTICES));
    assign do_append  = in_acc && (i_in_data.command == pip_pkg::CMD_APPEND) && !store_full;
    assign last_idx   = AW'(r_vcount - CW'(1));
    assign walk_busy  = r_rd_v || r_close || edge_st.busy;
    assign out_free   = !r_out_valid || i_out_ready;

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pip_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.command == pip_pkg::CMD_QUERY && r_vcount != '0) begin
                        n_state = pip_pkg::ST_WALK;
                    end else begin
                        n_state = pip_pkg::ST_FINISH;
                    end
                end
            end
            pip_pkg::ST_WALK: begin
                if (r_idx == last_idx) begin
                    n_state = pip_pkg::ST_DRAIN;
                end
            end
            pip_pkg::ST_DRAIN: begin
                if (!walk_busy) begin
                    n_state = pip_pkg::ST_FINISH;
                end
            end
            pip_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = pip_pkg::ST_IDLE;
                end
            end
            default: n_state = pip_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pip_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Vertex store: written on append, read once per cycle at the walk index.
    always_ff @(posedge i_clk) begin
        if (do_append) begin
            mem_x[r_vcount[AW-1:0]] <= i_in_data.point_x;
            mem_y[r_vcount[AW-1:0]] <= i_in_data.point_y;
        end
        r_rd_x <= mem_x[r_idx];
        r_rd_y <= mem_y[r_idx];
    end

    // Command latch, vertex count and walk index.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_in_data.command;
            r_px   <= i_in_data.point_x;
            r_py   <= i_in_data.point_y;
            r_full <= (i_in_data.command == pip_pkg::CMD_APPEND) && store_full;
        end
        if (!i_rst_n) begin
            r_vcount    <= '0;
            r_idx       <= '0;
            r_rd_v      <= 1'b0;
            r_rd_last   <= 1'b0;
            r_close     <= 1'b0;
            r_have_prev <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (do_append) begin
                r_vcount <= r_vcount + CW'(1);
            end else if (in_acc && i_in_data.command == pip_pkg::CMD_CLEAR) begin
                r_vcount <= '0;
            end

            // Issue one read per cycle while walking.
            r_rd_v    <= (r_state == pip_pkg::ST_WALK);
            r_rd_last <= (r_state == pip_pkg::ST_WALK) && (r_idx == last_idx);
            if (in_acc) begin
                r_idx <= '0;
            end else if (r_state == pip_pkg::ST_WALK && r_idx != last_idx) begin
                r_idx <= r_idx + AW'(1);
            end

            // The closing edge follows the read of the last vertex.
            r_close <= r_rd_v && r_rd_last;

            // Track the previous and the first vertex of the walk.
            if (in_acc) begin
                r_have_prev <= 1'b0;
            end else if (r_rd_v) begin
                r_have_prev <= 1'b1;
            end

            // Count the crossings reported by the edge unit.
            if (in_acc) begin
                r_cnt <= '0;
            end else if (edge_st.hit_valid && edge_st.hit) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_prev_x <= r_rd_x;
            r_prev_y <= r_rd_y;
            if (!r_have_prev) begin
                r_first_x <= r_rd_x;
                r_first_y <= r_rd_y;
            end
        end
    end

    // Edge for the shared unit: previous vertex to the one just read, or
    // the last vertex back to the first.
    always_comb begin
        edge_in.valid = (r_rd_v && r_have_prev) || r_close;
        edge_in.ax    = r_prev_x;
        edge_in.ay    = r_prev_y;
        edge_in.bx    = r_close ? r_first_x : r_rd_x;
        edge_in.by    = r_close ? r_first_y : r_rd_y;
    end

    pip_edge_unit u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_edge   (edge_in),
        .i_px     (r_px),
        .i_py     (r_py),
        .o_status (edge_st)
    );

    // Result word; the crossing count saturates at its field's ceiling.
    always_comb begin
        result.inside_res = (r_cmd == pip_pkg::CMD_QUERY) && r_cnt[0];
        if (r_cmd != pip_pkg::CMD_QUERY) begin
            result.crossings = '0;
        end else if (32'(r_cnt) > 32'(pip_pkg::CROSS_MAX)) begin
            result.crossings = pip_pkg::CROSS_BITS'(pip_pkg::CROSS_MAX);
        end else begin
            result.crossings = pip_pkg::CROSS_BITS'(r_cnt);
        end
        result.full_error = r_full;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (r_state == pip_pkg::ST_FINISH && out_free) begin
            r_out <= result;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == pip_pkg::ST_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### sv/pip_checker.sv
// ----------------------------------------------------------------------------
// pip_checker: port-level checks for the point-in-polygon test
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module pip_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input pip_pkg::t_in_word  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pip_pkg::t_out_word o_out_data
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // The block is busy in the cycle after it takes a word.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after a word");

    // A dropped append reports no crossings.
    a_full_no_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.full_error |->
            o_out_data.crossings == '0 && !o_out_data.inside_res)
        else $error("full flag together with query fields");

    // An inside point has at least one crossing.
    a_inside_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.inside_res |-> o_out_data.crossings != '0)
        else $error("inside reported with zero crossings");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
